// ===== hdl/cancellable_timer_queue_defines.svh =====
// assertion macros for the timer queue
`ifndef CANCELLABLE_TIMER_QUEUE_DEFINES_SVH
`define CANCELLABLE_TIMER_QUEUE_DEFINES_SVH
`ifndef ASSERT_OFF
`define CTQ_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("timer queue assertion failed");
`define CTQ_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("timer queue forbidden condition");
`else
`define CTQ_ASSERT(lbl, prop)
`define CTQ_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== hdl/ctq_pkg.sv =====
package ctq_pkg;

	localparam int CAPACITY_DEF  = 16;
	localparam int TIME_BITS_DEF = 48;
	localparam int ID_BITS_DEF   = 32;

	// most expiries released by one tick
	localparam int MAX_OUT = 16;

	localparam int ACTION_W = 2;
	localparam int DELAY_W  = 32;
	localparam int TARGET_W = 32;
	localparam int KIND_W   = 3;
	localparam int TID_W    = 32;
	localparam int COUNT_W  = 5;

	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK       = 2'd0,
		ACT_ADD        = 2'd1,
		ACT_CANCEL     = 2'd2,
		ACT_CANCEL_ALL = 2'd3
	} action_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD        = 3'd0,
		KIND_CANCEL     = 3'd1,
		KIND_CANCEL_ALL = 3'd2,
		KIND_EXPIRY     = 3'd3,
		KIND_IDLE       = 3'd4
	} kind_t;

	// slot flag updates, all at the write address but abort_all
	typedef struct packed {
		logic set_used;
		logic set_abort;
		logic abort_all;
		logic clr_used;
	} flag_op_t;

endpackage

// ===== hdl/ctq_cmp.sv =====
module ctq_cmp #(
	parameter int KEY_W = 113
) (
	input  logic [KEY_W-1:0] a,
	input  logic [KEY_W-1:0] b,
	output logic             lt,
	output logic             eq
);

	// shared key comparator
	assign lt = a < b;
	assign eq = a == b;

endmodule

// ===== hdl/ctq_store.sv =====
module ctq_store #(
	parameter int CAPACITY  = ctq_pkg::CAPACITY_DEF,
	parameter int TIME_BITS = ctq_pkg::TIME_BITS_DEF,
	parameter int ID_BITS   = ctq_pkg::ID_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [$clog2(CAPACITY)-1:0] rd_addr,
	input  logic                        wr_en,
	input  logic [$clog2(CAPACITY)-1:0] wr_addr,
	input  logic [TIME_BITS-1:0]        wr_deadline,
	input  logic [ID_BITS-1:0]          wr_ident,
	input  ctq_pkg::flag_op_t           flag_op,
	output logic                        rd_used_s1,
	output logic                        rd_aborted_s1,
	output logic [TIME_BITS-1:0]        rd_deadline_s1,
	output logic [ID_BITS-1:0]          rd_ident_s1
);
	import ctq_pkg::*;

	logic [CAPACITY-1:0]  used_q;
	logic [CAPACITY-1:0]  aborted_q;
	logic [TIME_BITS-1:0] deadline_mem [CAPACITY];
	logic [ID_BITS-1:0]   ident_mem [CAPACITY];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			aborted_q <= '0;
		end else begin
			if (flag_op.abort_all) begin
				aborted_q <= aborted_q | used_q;
			end
			if (flag_op.set_used) begin
				used_q[wr_addr]    <= 1'b1;
				aborted_q[wr_addr] <= 1'b0;
			end
			if (flag_op.set_abort) begin
				aborted_q[wr_addr] <= 1'b1;
			end
			if (flag_op.clr_used) begin
				used_q[wr_addr]    <= 1'b0;
				aborted_q[wr_addr] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			deadline_mem[wr_addr] <= wr_deadline;
			ident_mem[wr_addr]    <= wr_ident;
		end
		if (rd_en) begin
			rd_deadline_s1 <= deadline_mem[rd_addr];
			rd_ident_s1    <= ident_mem[rd_addr];
			rd_used_s1     <= used_q[rd_addr];
			rd_aborted_s1  <= aborted_q[rd_addr];
		end
	end

endmodule

// ===== hdl/cancellable_timer_queue.sv =====
// add, cancel, cancel-all: one slot scan, then the result strobe
// tick releasing k timers (k < 16): k+1 slot scans, then idle
// tick releasing 16 timers: 16 scans plus a flush state; expiries come at most one per cycle
// every scan walks the slot store one entry a cycle through its single read port and comparator
// results are one-cycle strobes that the receiver cannot stall
// asynchronous active-low reset empties all slots and zeroes the tick and identifier counters
`include "cancellable_timer_queue_defines.svh"

module cancellable_timer_queue #(
	parameter int CAPACITY  = ctq_pkg::CAPACITY_DEF,
	parameter int TIME_BITS = ctq_pkg::TIME_BITS_DEF,
	parameter int ID_BITS   = ctq_pkg::ID_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [ctq_pkg::ACTION_W-1:0] action,
	input  logic [ctq_pkg::DELAY_W-1:0]  delay_ticks,
	input  logic [ctq_pkg::TARGET_W-1:0] target_id,
	output logic                         valid,
	output logic [ctq_pkg::KIND_W-1:0]   kind,
	output logic [ctq_pkg::TID_W-1:0]    timer_id,
	output logic                         aborted,
	output logic                         ok,
	output logic [ctq_pkg::COUNT_W-1:0]  count,
	output logic                         last
);
	import ctq_pkg::*;

	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int NOUT_W = $clog2(MAX_OUT + 1);
	localparam int CW     = (ID_BITS > TARGET_W) ? ID_BITS : TARGET_W;
	localparam int KEY_W  = 1 + TIME_BITS + CW;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_LAST  = 5'b00100,
		ST_ACT   = 5'b01000,
		ST_FLUSH = 5'b10000
	} state_t;

	state_t               state_q;
	action_t              action_q;
	logic [DELAY_W-1:0]   delay_q;
	logic [TARGET_W-1:0]  target_q;
	logic [TIME_BITS-1:0] tick_now_q;
	logic [ID_BITS-1:0]   last_id_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 valid_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 best_valid_q;
	logic [IDX_W-1:0]     best_slot_q;
	logic                 best_ab_q;
	logic [TIME_BITS-1:0] best_dl_q;
	logic [ID_BITS-1:0]   best_id_q;
	logic                 pend_q;
	logic                 pend_ab_q;
	logic [ID_BITS-1:0]   pend_id_q;
	logic [NOUT_W-1:0]    n_q;
	logic [CNT_W-1:0]     cnt_q;

	logic                 res_valid_q;
	kind_t                res_kind_q;
	logic [TID_W-1:0]     res_id_q;
	logic                 res_ab_q;
	logic                 res_ok_q;
	logic [COUNT_W-1:0]   res_count_q;
	logic                 res_last_q;

	logic                 accept;
	logic                 rd_used_s1;
	logic                 rd_aborted_s1;
	logic [TIME_BITS-1:0] rd_deadline_s1;
	logic [ID_BITS-1:0]   rd_ident_s1;
	flag_op_t             flag_op;
	logic [KEY_W-1:0]     key_a;
	logic [KEY_W-1:0]     key_b;
	logic                 key_lt;
	logic                 key_eq;
	logic                 due;
	logic                 take;
	logic [ID_BITS-1:0]   id_inc;
	logic [ID_BITS-1:0]   next_id;
	logic [TIME_BITS:0]   dl_sum;
	logic [TIME_BITS-1:0] new_deadline;
	logic [COUNT_W-1:0]   cnt_sat;

	assign busy   = state_q != ST_IDLE;
	assign accept = start && !busy;

	assign id_inc  = last_id_q + ID_BITS'(1);
	assign next_id = (id_inc == '0) ? ID_BITS'(1) : id_inc;

	assign dl_sum       = {1'b0, tick_now_q} + (TIME_BITS + 1)'(delay_q);
	assign new_deadline = dl_sum[TIME_BITS] ? '1 : dl_sum[TIME_BITS-1:0];

	assign cnt_sat = (32'(cnt_q) > 32'd31) ? COUNT_W'(31) : COUNT_W'(cnt_q);

	assign due = rd_used_s1 && (rd_aborted_s1 || rd_deadline_s1 <= tick_now_q);

	// identifier match for cancel, emission order key otherwise
	always_comb begin
		if (action_q == ACT_CANCEL) begin
			key_a = {1'b0, {TIME_BITS{1'b0}}, CW'(rd_ident_s1)};
			key_b = {1'b0, {TIME_BITS{1'b0}}, CW'(target_q)};
		end else begin
			key_a = {~rd_aborted_s1, rd_deadline_s1, CW'(rd_ident_s1)};
			key_b = {~best_ab_q, best_dl_q, CW'(best_id_q)};
		end
	end

	ctq_cmp #(
		.KEY_W(KEY_W)
	) u_cmp (
		.a (key_a),
		.b (key_b),
		.lt(key_lt),
		.eq(key_eq)
	);

	always_comb begin
		unique case (action_q)
			ACT_TICK:       take = due && (!best_valid_q || key_lt);
			ACT_ADD:        take = !rd_used_s1 && !best_valid_q;
			ACT_CANCEL:     take = rd_used_s1 && !rd_aborted_s1 && key_eq && !best_valid_q;
			ACT_CANCEL_ALL: take = 1'b0;
			default:        take = 1'b0;
		endcase
	end

	always_comb begin
		flag_op           = '0;
		flag_op.set_used  = (state_q == ST_ACT) && (action_q == ACT_ADD) && best_valid_q;
		flag_op.set_abort = (state_q == ST_ACT) && (action_q == ACT_CANCEL) && best_valid_q;
		flag_op.abort_all = (state_q == ST_ACT) && (action_q == ACT_CANCEL_ALL);
		flag_op.clr_used  = (state_q == ST_ACT) && (action_q == ACT_TICK) && best_valid_q;
	end

	ctq_store #(
		.CAPACITY (CAPACITY),
		.TIME_BITS(TIME_BITS),
		.ID_BITS  (ID_BITS)
	) u_store (
		.clk           (clk),
		.arst_n        (arst_n),
		.rd_en         (state_q == ST_SCAN),
		.rd_addr       (idx_q),
		.wr_en         (flag_op.set_used),
		.wr_addr       (best_slot_q),
		.wr_deadline   (new_deadline),
		.wr_ident      (next_id),
		.flag_op       (flag_op),
		.rd_used_s1    (rd_used_s1),
		.rd_aborted_s1 (rd_aborted_s1),
		.rd_deadline_s1(rd_deadline_s1),
		.rd_ident_s1   (rd_ident_s1)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			valid_s1     <= 1'b0;
			best_valid_q <= 1'b0;
			pend_q       <= 1'b0;
			n_q          <= '0;
			cnt_q        <= '0;
			tick_now_q   <= '0;
			last_id_q    <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			valid_s1    <= state_q == ST_SCAN;
			if (valid_s1 && take) begin
				best_valid_q <= 1'b1;
			end
			if (valid_s1 && action_q == ACT_CANCEL_ALL && rd_used_s1) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q      <= ST_SCAN;
						idx_q        <= '0;
						best_valid_q <= 1'b0;
						pend_q       <= 1'b0;
						n_q          <= '0;
						cnt_q        <= '0;
						if (action_t'(action) == ACT_TICK && tick_now_q != '1) begin
							tick_now_q <= tick_now_q + TIME_BITS'(1);
						end
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + IDX_W'(1);
					if (idx_q == IDX_W'(CAPACITY - 1)) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					state_q <= ST_ACT;
				end
				ST_ACT: begin
					if (action_q == ACT_TICK && best_valid_q) begin
						res_valid_q <= pend_q;
						pend_q      <= 1'b1;
						n_q         <= n_q + NOUT_W'(1);
						if (n_q == NOUT_W'(MAX_OUT - 1)) begin
							state_q <= ST_FLUSH;
						end else begin
							state_q      <= ST_SCAN;
							idx_q        <= '0;
							best_valid_q <= 1'b0;
						end
					end else begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
						if (action_q == ACT_ADD && best_valid_q) begin
							last_id_q <= next_id;
						end
					end
				end
				ST_FLUSH: begin
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// transaction payload, scan candidates and result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action_t'(action);
			delay_q  <= delay_ticks;
			target_q <= target_id;
		end
		if (state_q == ST_SCAN) begin
			idx_s1 <= idx_q;
		end
		if (valid_s1 && take) begin
			best_slot_q <= idx_s1;
			best_ab_q   <= rd_aborted_s1;
			best_dl_q   <= rd_deadline_s1;
			best_id_q   <= rd_ident_s1;
		end
		if (state_q == ST_ACT) begin
			res_id_q    <= '0;
			res_ab_q    <= 1'b0;
			res_ok_q    <= 1'b0;
			res_count_q <= '0;
			res_last_q  <= 1'b1;
			unique case (action_q)
				ACT_ADD: begin
					res_kind_q <= KIND_ADD;
					res_ok_q   <= best_valid_q;
					res_id_q   <= best_valid_q ? TID_W'(next_id) : '0;
				end
				ACT_CANCEL: begin
					res_kind_q <= KIND_CANCEL;
					res_ok_q   <= best_valid_q;
				end
				ACT_CANCEL_ALL: begin
					res_kind_q  <= KIND_CANCEL_ALL;
					res_count_q <= cnt_sat;
				end
				ACT_TICK: begin
					if (best_valid_q || pend_q) begin
						res_kind_q <= KIND_EXPIRY;
						res_id_q   <= TID_W'(pend_id_q);
						res_ab_q   <= pend_ab_q;
						res_last_q <= !best_valid_q;
					end else begin
						res_kind_q <= KIND_IDLE;
					end
					if (best_valid_q) begin
						pend_id_q <= best_id_q;
						pend_ab_q <= best_ab_q;
					end
				end
				default: begin
					res_kind_q <= KIND_IDLE;
				end
			endcase
		end
		if (state_q == ST_FLUSH) begin
			res_kind_q  <= KIND_EXPIRY;
			res_id_q    <= TID_W'(pend_id_q);
			res_ab_q    <= pend_ab_q;
			res_ok_q    <= 1'b0;
			res_count_q <= '0;
			res_last_q  <= 1'b1;
		end
	end

	assign valid    = res_valid_q;
	assign kind     = res_kind_q;
	assign timer_id = res_id_q;
	assign aborted  = res_ab_q;
	assign ok       = res_ok_q;
	assign count    = res_count_q;
	assign last     = res_last_q;

	`CTQ_ASSERT(a_res_from_act, valid |-> ($past(state_q) == ST_ACT || $past(state_q) == ST_FLUSH))
	`CTQ_ASSERT(a_last_frees, valid && last |-> !busy)
	`CTQ_ASSERT(a_only_expiry_chained, valid && !last |-> res_kind_q == KIND_EXPIRY)
	`CTQ_ASSERT(a_release_bound, n_q <= NOUT_W'(MAX_OUT))
	`CTQ_ASSERT_NEVER(a_no_read_idle, valid_s1 && state_q == ST_IDLE)

endmodule

// ===== tb/sv/tb_cancellable_timer_queue.sv =====
module tb_cancellable_timer_queue;
	import ctq_pkg::*;

	localparam int SLOTS = CAPACITY_DEF;
	localparam logic [TIME_BITS_DEF-1:0] TIME_MAX = '1;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 3 * (CAPACITY_DEF + 3);

	typedef struct packed {
		kind_t              kind;
		logic [TID_W-1:0]   tid;
		logic               aborted;
		logic               ok;
		logic [COUNT_W-1:0] count;
		logic               last;
	} timer_result_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	action_t             action;
	logic [DELAY_W-1:0]  delay_ticks;
	logic [TARGET_W-1:0] target_id;
	logic                valid;
	logic [KIND_W-1:0]   kind;
	logic [TID_W-1:0]    timer_id;
	logic                aborted;
	logic                ok;
	logic [COUNT_W-1:0]  count;
	logic                last;

	cancellable_timer_queue dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.delay_ticks (delay_ticks),
		.target_id   (target_id),
		.valid       (valid),
		.kind        (kind),
		.timer_id    (timer_id),
		.aborted     (aborted),
		.ok          (ok),
		.count       (count),
		.last        (last)
	);

	// shadow of the timer store
	logic                     slot_used    [SLOTS];
	logic                     slot_aborted [SLOTS];
	logic [TIME_BITS_DEF-1:0] slot_deadline[SLOTS];
	logic [TID_W-1:0]         slot_ident   [SLOTS];
	logic [TIME_BITS_DEF-1:0] tick_now;
	logic [TID_W-1:0]         last_issued_id;

	timer_result_t pending_results[$];

	int cycles;
	int mismatches;
	int sent;
	int checked;
	int expiries;
	int aborted_expiries;
	int refused_adds;
	int nogap_left;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic slot_due(input int s);
		return slot_used[s] && (slot_aborted[s] || slot_deadline[s] <= tick_now);
	endfunction

	function automatic logic fires_ahead(input int a, input int b);
		if (slot_aborted[a] != slot_aborted[b])
			return slot_aborted[a];
		if (slot_deadline[a] != slot_deadline[b])
			return slot_deadline[a] < slot_deadline[b];
		return slot_ident[a] < slot_ident[b];
	endfunction

	function automatic logic any_due();
		for (int s = 0; s < SLOTS; s++)
			if (slot_due(s))
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic store_full();
		for (int s = 0; s < SLOTS; s++)
			if (!slot_used[s])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic predict_command(input action_t act, input logic [DELAY_W-1:0] dly,
			input logic [TARGET_W-1:0] tgt);
		timer_result_t r;
		int free_slot;
		int best;
		int released;
		logic found;
		logic [COUNT_W:0] occupied;
		logic [TIME_BITS_DEF-1:0] span;
		r = '{kind: KIND_IDLE, tid: '0, aborted: 1'b0, ok: 1'b0, count: '0, last: 1'b1};
		case (act)
			ACT_ADD: begin
				free_slot = -1;
				for (int s = SLOTS - 1; s >= 0; s--)
					if (!slot_used[s])
						free_slot = s;
				r.kind = KIND_ADD;
				if (free_slot < 0) begin
					refused_adds++;
				end else begin
					last_issued_id = last_issued_id + 1'b1;
					if (last_issued_id == '0)
						last_issued_id = 1;
					span = TIME_BITS_DEF'(dly);
					slot_used[free_slot] = 1'b1;
					slot_aborted[free_slot] = 1'b0;
					slot_ident[free_slot] = last_issued_id;
					slot_deadline[free_slot] = (span > TIME_MAX - tick_now) ? TIME_MAX
							: tick_now + span;
					r.tid = last_issued_id;
					r.ok = 1'b1;
				end
				pending_results.push_back(r);
			end
			ACT_CANCEL: begin
				found = 1'b0;
				for (int s = 0; s < SLOTS; s++) begin
					if (!found && slot_used[s] && !slot_aborted[s] && slot_ident[s] == tgt) begin
						slot_aborted[s] = 1'b1;
						found = 1'b1;
					end
				end
				r.kind = KIND_CANCEL;
				r.ok = found;
				pending_results.push_back(r);
			end
			ACT_CANCEL_ALL: begin
				occupied = '0;
				for (int s = 0; s < SLOTS; s++) begin
					if (slot_used[s]) begin
						slot_aborted[s] = 1'b1;
						occupied++;
					end
				end
				r.kind = KIND_CANCEL_ALL;
				r.count = (occupied > 31) ? 5'd31 : occupied[COUNT_W-1:0];
				pending_results.push_back(r);
			end
			default: begin
				if (tick_now != TIME_MAX)
					tick_now++;
				released = 0;
				while (released < MAX_OUT && any_due()) begin
					best = -1;
					for (int s = 0; s < SLOTS; s++)
						if (slot_due(s) && (best < 0 || fires_ahead(s, best)))
							best = s;
					r.kind = KIND_EXPIRY;
					r.tid = slot_ident[best];
					r.aborted = slot_aborted[best];
					slot_used[best] = 1'b0;
					slot_aborted[best] = 1'b0;
					released++;
					r.last = !(released < MAX_OUT && any_due());
					pending_results.push_back(r);
				end
				if (released == 0)
					pending_results.push_back(r);
			end
		endcase
	endtask

	task automatic issue(input action_t act, input logic [DELAY_W-1:0] dly,
			input logic [TARGET_W-1:0] tgt);
		int gap;
		if (nogap_left > 0) begin
			nogap_left--;
			gap = 0;
		end else begin
			gap = $urandom_range(0, 10);
			if ($urandom_range(0, 9) == 0)
				nogap_left = 8;
		end
		if (gap > 0) begin
			start = 1'b0;
			if ($urandom_range(0, 1) == 1)
				while (busy)
					@(negedge clk);
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		action = act;
		delay_ticks = dly;
		target_id = tgt;
		do @(posedge clk); while (busy);
		predict_command(act, dly, tgt);
		sent++;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		timer_result_t want;
		if (arst_n && valid) begin
			checked++;
			if (kind == KIND_EXPIRY) begin
				expiries++;
				if (aborted)
					aborted_expiries++;
			end
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0d id %0h aborted %0b ok %0b count %0d last %0b",
							kind, timer_id, aborted, ok, count, last);
			end else begin
				want = pending_results.pop_front();
				if (kind != want.kind || timer_id != want.tid || aborted != want.aborted ||
						ok != want.ok || count != want.count || last != want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("mismatch (expected/actual): kind %0d/%0d id %0h/%0h ",
								want.kind, kind, want.tid, timer_id);
						$display("aborted %0b/%0b ok %0b/%0b count %0d/%0d last %0b/%0b",
								want.aborted, aborted, want.ok, ok, want.count, count,
								want.last, last);
					end
				end
			end
		end
	end

	task automatic test_idle_tick();
		issue(ACT_TICK, $urandom, $urandom);
	endtask

	task automatic test_fill_store();
		issue(ACT_ADD, 32'd0, $urandom);
		issue(ACT_ADD, 32'hFFFF_FFFF, $urandom);
		issue(ACT_ADD, 32'd1, $urandom);
		issue(ACT_ADD, 32'h8000_0000, $urandom);
		repeat (SLOTS - 4) issue(ACT_ADD, $urandom_range(0, 3), $urandom);
		issue(ACT_ADD, $urandom_range(0, 3), $urandom);
	endtask

	task automatic test_cancel_one();
		issue(ACT_CANCEL, $urandom, slot_ident[1]);
		issue(ACT_CANCEL, $urandom, slot_ident[1]);
		issue(ACT_CANCEL, $urandom, 32'd0);
		issue(ACT_CANCEL, $urandom, 32'hFFFF_FFFF);
	endtask

	task automatic test_tick_release();
		issue(ACT_TICK, $urandom, $urandom);
	endtask

	task automatic test_cancel_all();
		issue(ACT_CANCEL_ALL, $urandom, $urandom);
		issue(ACT_TICK, $urandom, $urandom);
	endtask

	// fill every slot, abort them all, then one tick must release sixteen
	task automatic test_mass_expiry();
		while (!store_full())
			issue(ACT_ADD, $urandom_range(0, 20), $urandom);
		issue(ACT_CANCEL_ALL, $urandom, $urandom);
		issue(ACT_TICK, $urandom, $urandom);
	endtask

	task automatic test_random_mix(input int n);
		int pick;
		int s;
		logic [DELAY_W-1:0] dly;
		logic [TARGET_W-1:0] tgt;
		for (int j = 0; j < n; j++) begin
			dly = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 6);
			tgt = $urandom;
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				issue(ACT_ADD, dly, tgt);
			end else if (pick < 70) begin
				issue(ACT_TICK, dly, tgt);
			end else if (pick < 94) begin
				s = $urandom_range(0, SLOTS - 1);
				if (slot_used[s] && $urandom_range(0, 4) != 0)
					tgt = slot_ident[s];
				issue(ACT_CANCEL, dly, tgt);
			end else begin
				issue(ACT_CANCEL_ALL, dly, tgt);
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_TICK;
		delay_ticks = '0;
		target_id = '0;
		cycles = 0;
		mismatches = 0;
		sent = 0;
		checked = 0;
		expiries = 0;
		aborted_expiries = 0;
		refused_adds = 0;
		nogap_left = 0;
		tick_now = '0;
		last_issued_id = '0;
		for (int s = 0; s < SLOTS; s++) begin
			slot_used[s] = 1'b0;
			slot_aborted[s] = 1'b0;
			slot_deadline[s] = '0;
			slot_ident[s] = '0;
		end
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_idle_tick();
		test_fill_store();
		test_cancel_one();
		test_tick_release();
		test_cancel_all();
		test_random_mix(45);
		test_mass_expiry();
		test_random_mix(45);

		start = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d transactions sent, %0d results checked, %0d mismatches",
				sent, checked, mismatches);
		$display("%0d expiries (%0d aborted), %0d adds refused on a full store",
				expiries, aborted_expiries, refused_adds);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
